/* src/rc6_pkg.sv */
// ----------------------------------------------------------------------------
// rc6_pkg
// Shared types, constants and word functions for the RC6 block cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package rc6_pkg;

  // Word and rotation sizes.
  localparam int WORD_BITS = 32;
  localparam int ROT_W     = 5;

  // Defaults for the top-level parameters.
  localparam int MAX_ROUNDS_DEF    = 20;
  localparam int MAX_KEY_BYTES_DEF = 32;

  // Configuration port sizes and reset values.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int KEY_BITS   = 4 * CFG_DATA_W;
  localparam int ROUNDS_W   = 5;
  localparam int KEYLEN_W   = 6;
  localparam logic [ROUNDS_W-1:0] RESET_ROUNDS     = 5'd20;
  localparam logic [KEYLEN_W-1:0] RESET_KEY_LENGTH = 6'd16;

  typedef logic [WORD_BITS-1:0] word_t;

  // Magic constants of the key schedule.
  localparam word_t P32 = 32'hB7E1_5163;
  localparam word_t Q32 = 32'h9E37_79B9;

  // Fixed rotations.
  localparam logic [ROT_W-1:0] QUAD_ROT = 5'd5;
  localparam logic [ROT_W-1:0] MIX_ROT  = 5'd3;

  // Command codes of an input word.
  typedef enum logic [1:0] {
    CMD_EXPAND  = 2'd0,
    CMD_ENCRYPT = 2'd1,
    CMD_DECRYPT = 2'd2
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROUNDS     = 3'd0,
    CFG_KEY_LENGTH = 3'd1,
    CFG_KEY_LO     = 3'd2,
    CFG_KEY_MID_LO = 3'd3,
    CFG_KEY_MID_HI = 3'd4,
    CFG_KEY_HI     = 3'd5
  } cfg_idx_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEYLOAD,
    ST_FILL,
    ST_MIX_RD,
    ST_MIX_A,
    ST_MIX_B,
    ST_PRE_RD,
    ST_PRE_APPLY,
    ST_MUL,
    ST_ROUND,
    ST_POST,
    ST_FINISH
  } rc6_state_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_KEYLOAD,
    OP_FILL,
    OP_MIX_A,
    OP_MIX_B,
    OP_PRE,
    OP_MUL,
    OP_ROUND,
    OP_POST
  } rc6_op_t;

  // Command bundle from the controller to the datapath.
  typedef struct packed {
    rc6_op_t op;
    logic    decrypt;
    logic    rd_en;
    logic    out_load;
    logic    out_zero;
    logic    out_status;
  } rc6_ctrl_t;

  // Rotate left; a rotation by zero passes the word through.
  function automatic word_t rotl(input word_t x, input logic [ROT_W-1:0] n);
    logic [2*WORD_BITS-1:0] dbl;
    dbl = {x, x} << n;
    return dbl[2*WORD_BITS-1:WORD_BITS];
  endfunction

  // Rotate right; a rotation by zero passes the word through.
  function automatic word_t rotr(input word_t x, input logic [ROT_W-1:0] n);
    logic [2*WORD_BITS-1:0] dbl;
    dbl = {x, x} >> n;
    return dbl[WORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/rc6_ctrl.sv */
// ----------------------------------------------------------------------------
// rc6_ctrl
// Sequencer for key expansion, encryption and decryption. Holds the loop
// counters, the latched key-schedule sizes and the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module rc6_ctrl #(
  parameter int MAX_ROUNDS    = rc6_pkg::MAX_ROUNDS_DEF,
  parameter int MAX_KEY_BYTES = rc6_pkg::MAX_KEY_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     cmd,
  input  wire logic [rc6_pkg::ROUNDS_W-1:0]   cfg_rounds,
  input  wire logic [rc6_pkg::KEYLEN_W-1:0]   cfg_key_length,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output rc6_pkg::rc6_ctrl_t                  ctrl,
  output logic [$clog2(2*MAX_ROUNDS+4)-1:0]   rd_base,
  output logic [$clog2(2*MAX_ROUNDS+4)-1:0]   wr_idx,
  output logic [(((MAX_KEY_BYTES+3)/4) > 1 ? $clog2((MAX_KEY_BYTES+3)/4) : 1)-1:0] kw_idx,
  output logic [$clog2(MAX_KEY_BYTES+1)-1:0]  key_len
);

  import rc6_pkg::*;

  localparam int TABLE_SIZE = 2 * MAX_ROUNDS + 4;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int KEY_WORDS  = (MAX_KEY_BYTES + 3) / 4;
  localparam int KW_IDX_W   = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int ROUND_W    = $clog2(MAX_ROUNDS + 1);
  localparam int BYTE_W     = $clog2(MAX_KEY_BYTES + 1);
  localparam int STEP_MAX   = 3 * ((KEY_WORDS > TABLE_SIZE) ? KEY_WORDS : TABLE_SIZE);
  localparam int STEP_W     = $clog2(STEP_MAX);

  rc6_state_t state, state_next;

  logic                keys_valid;
  logic [ROUND_W-1:0]  lat_r;
  logic [IDX_W-1:0]    nk_last;
  logic [KW_IDX_W-1:0] key_last;
  logic [STEP_W-1:0]   steps_last;
  logic                dec_mode;
  logic                res_zero;
  logic                res_status;
  logic [ROUND_W-1:0]  rnd;
  logic [IDX_W-1:0]    idx_i;
  logic [KW_IDX_W-1:0] idx_j;
  logic [STEP_W-1:0]   step;

  logic                in_accept;
  logic                is_block;
  logic [31:0]         r_sat;
  logic [31:0]         b_sat;
  logic [31:0]         c_cnt;
  logic [31:0]         nk_cnt;
  logic [31:0]         mx_cnt;
  logic [31:0]         steps_cnt;
  logic [IDX_W-1:0]    hi_base;
  logic [IDX_W-1:0]    pre_base;
  logic [IDX_W-1:0]    post_base;
  logic [ROUND_W-1:0]  rnd_next;
  logic                round_last;
  logic [IDX_W-1:0]    i_next;
  logic [KW_IDX_W-1:0] j_next;
  logic                mix_done;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign is_block  = (cmd == CMD_ENCRYPT) || (cmd == CMD_DECRYPT);
  assign wr_idx    = idx_i;
  assign kw_idx    = idx_j;

  // Key-schedule sizes from the configuration, saturated to the build limits.
  always_comb begin
    r_sat = (32'(cfg_rounds) > 32'(MAX_ROUNDS)) ? 32'(MAX_ROUNDS) : 32'(cfg_rounds);
    b_sat = (32'(cfg_key_length) > 32'(MAX_KEY_BYTES)) ? 32'(MAX_KEY_BYTES)
                                                       : 32'(cfg_key_length);
    c_cnt = (b_sat + 32'd3) >> 2;
    if (c_cnt == 32'd0) begin
      c_cnt = 32'd1;
    end
    nk_cnt    = (r_sat << 1) + 32'd4;
    mx_cnt    = (c_cnt > nk_cnt) ? c_cnt : nk_cnt;
    steps_cnt = (mx_cnt << 1) + mx_cnt - 32'd1;
  end

  // Table addresses and loop indexes.
  always_comb begin
    hi_base    = nk_last - IDX_W'(1);
    pre_base   = dec_mode ? hi_base : '0;
    post_base  = dec_mode ? '0 : hi_base;
    rnd_next   = dec_mode ? (rnd - ROUND_W'(1)) : (rnd + ROUND_W'(1));
    round_last = dec_mode ? (rnd == ROUND_W'(1)) : (rnd == lat_r);
    i_next     = (idx_i == nk_last) ? '0 : (idx_i + IDX_W'(1));
    j_next     = (idx_j == key_last) ? '0 : (idx_j + KW_IDX_W'(1));
    mix_done   = (step == steps_last);
  end

  // Next state and datapath commands.
  always_comb begin
    state_next      = state;
    ctrl            = '0;
    ctrl.op         = OP_NONE;
    ctrl.decrypt    = dec_mode;
    rd_base         = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (cmd) inside
            CMD_EXPAND: begin
              state_next = ST_KEYLOAD;
            end
            CMD_ENCRYPT, CMD_DECRYPT: begin
              if (keys_valid) begin
                ctrl.op    = OP_LOAD;
                state_next = ST_PRE_RD;
              end else begin
                state_next = ST_FINISH;
              end
            end
            default: begin
              state_next = ST_FINISH;
            end
          endcase
        end
      end
      ST_KEYLOAD: begin
        ctrl.op    = OP_KEYLOAD;
        state_next = ST_FILL;
      end
      ST_FILL: begin
        ctrl.op = OP_FILL;
        if (idx_i == nk_last) begin
          state_next = ST_MIX_RD;
        end
      end
      ST_MIX_RD: begin
        ctrl.rd_en = 1'b1;
        rd_base    = idx_i;
        state_next = ST_MIX_A;
      end
      ST_MIX_A: begin
        ctrl.op    = OP_MIX_A;
        state_next = ST_MIX_B;
      end
      ST_MIX_B: begin
        ctrl.op = OP_MIX_B;
        if (mix_done) begin
          state_next = ST_FINISH;
        end else begin
          ctrl.rd_en = 1'b1;
          rd_base    = i_next;
          state_next = ST_MIX_A;
        end
      end
      ST_PRE_RD: begin
        ctrl.rd_en = 1'b1;
        rd_base    = pre_base;
        state_next = ST_PRE_APPLY;
      end
      ST_PRE_APPLY: begin
        ctrl.op    = OP_PRE;
        ctrl.rd_en = 1'b1;
        if (lat_r == '0) begin
          rd_base    = post_base;
          state_next = ST_POST;
        end else begin
          rd_base    = IDX_W'({rnd, 1'b0});
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        ctrl.op    = OP_MUL;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        ctrl.op    = OP_ROUND;
        ctrl.rd_en = 1'b1;
        if (round_last) begin
          rd_base    = post_base;
          state_next = ST_POST;
        end else begin
          rd_base    = IDX_W'({rnd_next, 1'b0});
          state_next = ST_MUL;
        end
      end
      ST_POST: begin
        ctrl.op    = OP_POST;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // The result register is free when empty or being taken this cycle.
        if (!out_valid || !out_stall) begin
          ctrl.out_load   = 1'b1;
          ctrl.out_zero   = res_zero;
          ctrl.out_status = res_status;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register, output handshake and key status.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      keys_valid <= 1'b0;
      lat_r      <= '0;
    end else begin
      state <= state_next;
      if (ctrl.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_MIX_B && mix_done) begin
        keys_valid <= 1'b1;
      end
      if (in_accept && cmd == CMD_EXPAND) begin
        lat_r <= ROUND_W'(r_sat);
      end
    end
  end

  // Per-item settings, latched sizes and loop counters.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      dec_mode   <= (cmd == CMD_DECRYPT);
      res_zero   <= !(is_block && keys_valid);
      res_status <= is_block && !keys_valid;
      rnd        <= (cmd == CMD_DECRYPT) ? lat_r : ROUND_W'(1);
      if (cmd == CMD_EXPAND) begin
        nk_last    <= IDX_W'(nk_cnt - 32'd1);
        key_last   <= KW_IDX_W'(c_cnt - 32'd1);
        steps_last <= STEP_W'(steps_cnt);
        key_len    <= BYTE_W'(b_sat);
      end
    end
    unique case (state)
      ST_KEYLOAD: begin
        idx_i <= '0;
        idx_j <= '0;
        step  <= '0;
      end
      ST_FILL: begin
        idx_i <= i_next;
      end
      ST_MIX_B: begin
        idx_i <= i_next;
        idx_j <= j_next;
        step  <= step + STEP_W'(1);
      end
      ST_ROUND: begin
        rnd <= rnd_next;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/rc6_datapath.sv */
// ----------------------------------------------------------------------------
// rc6_datapath
// Block words, quadratic multipliers, round-key memory, key words and the
// key-mixing registers, driven by commands from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module rc6_datapath #(
  parameter int MAX_ROUNDS    = rc6_pkg::MAX_ROUNDS_DEF,
  parameter int MAX_KEY_BYTES = rc6_pkg::MAX_KEY_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire rc6_pkg::word_t                 word_a,
  input  wire rc6_pkg::word_t                 word_b,
  input  wire rc6_pkg::word_t                 word_c,
  input  wire rc6_pkg::word_t                 word_d,
  input  wire logic [rc6_pkg::KEY_BITS-1:0]   key_bytes,
  input  wire rc6_pkg::rc6_ctrl_t             ctrl,
  input  wire logic [$clog2(2*MAX_ROUNDS+4)-1:0] rd_base,
  input  wire logic [$clog2(2*MAX_ROUNDS+4)-1:0] wr_idx,
  input  wire logic [(((MAX_KEY_BYTES+3)/4) > 1 ? $clog2((MAX_KEY_BYTES+3)/4) : 1)-1:0] kw_idx,
  input  wire logic [$clog2(MAX_KEY_BYTES+1)-1:0] key_len,
  output rc6_pkg::word_t                      out_a,
  output rc6_pkg::word_t                      out_b,
  output rc6_pkg::word_t                      out_c,
  output rc6_pkg::word_t                      out_d,
  output logic                                status
);

  import rc6_pkg::*;

  localparam int TABLE_SIZE = 2 * MAX_ROUNDS + 4;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int KEY_WORDS  = (MAX_KEY_BYTES + 3) / 4;

  // Round-key memory: one write port, two registered read ports.
  word_t rk_mem [TABLE_SIZE];
  word_t rk_lo;
  word_t rk_hi;
  logic  mem_we;
  word_t mem_wdata;

  // Key words, mixing registers and fill value.
  word_t kw [KEY_WORDS];
  word_t ka;
  word_t kb;
  word_t fill_val;

  // Block words and registered products.
  word_t blk_a, blk_b, blk_c, blk_d;
  word_t pt, pu;

  word_t x_t, x_u;
  word_t t_val, u_val;
  word_t enc_a, enc_c;
  word_t dec_a, dec_c;
  word_t mix_a_new;
  word_t mix_ab;
  word_t mix_b_new;

  // Operand selection and round arithmetic.
  always_comb begin
    x_t       = ctrl.decrypt ? blk_a : blk_b;
    x_u       = ctrl.decrypt ? blk_c : blk_d;
    t_val     = rotl(pt, QUAD_ROT);
    u_val     = rotl(pu, QUAD_ROT);
    enc_a     = rotl(blk_a ^ t_val, u_val[ROT_W-1:0]) + rk_lo;
    enc_c     = rotl(blk_c ^ u_val, t_val[ROT_W-1:0]) + rk_hi;
    dec_a     = rotr(blk_d - rk_lo, u_val[ROT_W-1:0]) ^ t_val;
    dec_c     = rotr(blk_b - rk_hi, t_val[ROT_W-1:0]) ^ u_val;
    mix_a_new = rotl(rk_lo + ka + kb, MIX_ROT);
    mix_ab    = ka + kb;
    mix_b_new = rotl(kw[kw_idx] + mix_ab, mix_ab[ROT_W-1:0]);
    mem_we    = (ctrl.op == OP_FILL) || (ctrl.op == OP_MIX_A);
    mem_wdata = (ctrl.op == OP_FILL) ? fill_val : mix_a_new;
  end

  // Round-key memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      rk_mem[wr_idx] <= mem_wdata;
    end
    if (ctrl.rd_en) begin
      rk_lo <= rk_mem[rd_base];
      rk_hi <= rk_mem[{rd_base[IDX_W-1:1], 1'b1}];
    end
  end

  // Key schedule registers.
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_KEYLOAD: begin
        // Bytes at or beyond the key length count as zero.
        for (int w = 0; w < KEY_WORDS; w++) begin
          for (int k = 0; k < 4; k++) begin
            kw[w][8*k +: 8] <= (32'(4 * w + k) < 32'(key_len))
                               ? key_bytes[8*(4*w+k) +: 8] : 8'h00;
          end
        end
        ka       <= '0;
        kb       <= '0;
        fill_val <= P32;
      end
      OP_FILL: begin
        fill_val <= fill_val + Q32;
      end
      OP_MIX_A: begin
        ka <= mix_a_new;
      end
      OP_MIX_B: begin
        kw[kw_idx] <= mix_b_new;
        kb         <= mix_b_new;
      end
      default: begin
      end
    endcase
  end

  // Block words through whitening and rounds.
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        blk_a <= word_a;
        blk_b <= word_b;
        blk_c <= word_c;
        blk_d <= word_d;
      end
      OP_PRE: begin
        if (ctrl.decrypt) begin
          blk_a <= blk_a - rk_lo;
          blk_c <= blk_c - rk_hi;
        end else begin
          blk_b <= blk_b + rk_lo;
          blk_d <= blk_d + rk_hi;
        end
      end
      OP_MUL: begin
        pt <= x_t * {x_t[WORD_BITS-2:0], 1'b1};
        pu <= x_u * {x_u[WORD_BITS-2:0], 1'b1};
      end
      OP_ROUND: begin
        if (ctrl.decrypt) begin
          blk_a <= dec_a;
          blk_b <= blk_a;
          blk_c <= dec_c;
          blk_d <= blk_c;
        end else begin
          blk_a <= blk_b;
          blk_b <= enc_c;
          blk_c <= blk_d;
          blk_d <= enc_a;
        end
      end
      OP_POST: begin
        if (ctrl.decrypt) begin
          blk_b <= blk_b - rk_lo;
          blk_d <= blk_d - rk_hi;
        end else begin
          blk_a <= blk_a + rk_lo;
          blk_c <= blk_c + rk_hi;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_a  <= ctrl.out_zero ? '0 : blk_a;
      out_b  <= ctrl.out_zero ? '0 : blk_b;
      out_c  <= ctrl.out_zero ? '0 : blk_c;
      out_d  <= ctrl.out_zero ? '0 : blk_d;
      status <= ctrl.out_status;
    end
  end

endmodule

`default_nettype wire

/* src/rc6_block_cipher.sv */
// ----------------------------------------------------------------------------
// rc6_block_cipher
// Encrypt or decrypt: load, whitening, r rounds of a multiply state and a
// round state, final whitening. Expand key: table fill, then 3*max(c,2r+4)
// mixing steps. A block before expansion returns zero words with status set.
// No new word is taken until the result of the last one is loaded.
// Reset clears the controller, marks the keys invalid and restores the
// configuration defaults; the round-key memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module rc6_block_cipher #(
  parameter int MAX_ROUNDS    = rc6_pkg::MAX_ROUNDS_DEF,
  parameter int MAX_KEY_BYTES = rc6_pkg::MAX_KEY_BYTES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [rc6_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rc6_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      cmd,
  input  wire rc6_pkg::word_t                  word_a,
  input  wire rc6_pkg::word_t                  word_b,
  input  wire rc6_pkg::word_t                  word_c,
  input  wire rc6_pkg::word_t                  word_d,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output rc6_pkg::word_t                       out_a,
  output rc6_pkg::word_t                       out_b,
  output rc6_pkg::word_t                       out_c,
  output rc6_pkg::word_t                       out_d,
  output logic                                 status
);

  import rc6_pkg::*;

  localparam int IDX_W     = $clog2(2 * MAX_ROUNDS + 4);
  localparam int KEY_WORDS = (MAX_KEY_BYTES + 3) / 4;
  localparam int KW_IDX_W  = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int BYTE_W    = $clog2(MAX_KEY_BYTES + 1);

  // Configuration registers.
  logic [ROUNDS_W-1:0]   rounds;
  logic [KEYLEN_W-1:0]   key_length;
  logic [CFG_DATA_W-1:0] key_lo;
  logic [CFG_DATA_W-1:0] key_mid_lo;
  logic [CFG_DATA_W-1:0] key_mid_hi;
  logic [CFG_DATA_W-1:0] key_hi;

  rc6_ctrl_t             ctrl;
  logic [IDX_W-1:0]      rd_base;
  logic [IDX_W-1:0]      wr_idx;
  logic [KW_IDX_W-1:0]   kw_idx;
  logic [BYTE_W-1:0]     key_len;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      rounds     <= RESET_ROUNDS;
      key_length <= RESET_KEY_LENGTH;
      key_lo     <= '0;
      key_mid_lo <= '0;
      key_mid_hi <= '0;
      key_hi     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ROUNDS:     rounds     <= cfg_data[ROUNDS_W-1:0];
        CFG_KEY_LENGTH: key_length <= cfg_data[KEYLEN_W-1:0];
        CFG_KEY_LO:     key_lo     <= cfg_data;
        CFG_KEY_MID_LO: key_mid_lo <= cfg_data;
        CFG_KEY_MID_HI: key_mid_hi <= cfg_data;
        CFG_KEY_HI:     key_hi     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  rc6_ctrl #(
    .MAX_ROUNDS    (MAX_ROUNDS),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .cfg_rounds     (rounds),
    .cfg_key_length (key_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .ctrl           (ctrl),
    .rd_base        (rd_base),
    .wr_idx         (wr_idx),
    .kw_idx         (kw_idx),
    .key_len        (key_len)
  );

  // Datapath.
  rc6_datapath #(
    .MAX_ROUNDS    (MAX_ROUNDS),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_datapath (
    .clk       (clk),
    .word_a    (word_a),
    .word_b    (word_b),
    .word_c    (word_c),
    .word_d    (word_d),
    .key_bytes ({key_hi, key_mid_hi, key_mid_lo, key_lo}),
    .ctrl      (ctrl),
    .rd_base   (rd_base),
    .wr_idx    (wr_idx),
    .kw_idx    (kw_idx),
    .key_len   (key_len),
    .out_a     (out_a),
    .out_b     (out_b),
    .out_c     (out_c),
    .out_d     (out_d),
    .status    (status)
  );

endmodule

`default_nettype wire

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RC6 block cipher. A short table of directed
// words goes first: blocks before any key expansion, the unused command,
// extreme data and repeated expansions. A series of key settings follows,
// with random words checked against a behavioural cipher model kept in this
// bench. The settings include zero and saturating round counts and key
// lengths, and register changes that are not followed by a new expansion.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rc6_pkg::*;

  // The one command code that has no member in the package enum.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic STATUS_OK            = 1'b0;
  localparam logic STATUS_KEY_NOT_READY = 1'b1;
  localparam int   TABLE_DEPTH = 2 * MAX_ROUNDS_DEF + 4;
  localparam int   NUM_PHASES  = 12;
  localparam int   PHASE_WORDS = 160;
  localparam int   HOLD_CYCLES = 300;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    logic  status;
  } block_res_t;

  typedef struct {
    logic [1:0] op;
    word_t      a;
    word_t      b;
    word_t      c;
    word_t      d;
    bit         typed;
    logic       want_status;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            cmd;
  word_t                 word_a, word_b, word_c, word_d;
  logic                  out_valid;
  logic                  out_stall;
  word_t                 out_a, out_b, out_c, out_d;
  logic                  status;

  // Model state: round keys, key words and the copy of the registers.
  word_t       sched_keys [TABLE_DEPTH];
  word_t       key_mix [8];
  bit          keys_ok;
  int unsigned used_rounds;
  logic [4:0]  set_rounds;
  logic [5:0]  set_key_len;
  logic [63:0] set_key [4];

  block_res_t due_blocks [$];
  block_res_t last_enc;
  int         err_count;
  int         send_idle_pct;
  int         recv_idle_pct;
  bit         hold_req;
  dir_row_t   dir_tab [15];

  rc6_block_cipher uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .word_a    (word_a),
    .word_b    (word_b),
    .word_c    (word_c),
    .word_d    (word_d),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_a     (out_a),
    .out_b     (out_b),
    .out_c     (out_c),
    .out_d     (out_d),
    .status    (status)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall time limit.
  initial begin
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Rotations keep a zero amount as a plain pass-through.
  function automatic word_t rot_left(word_t x, logic [4:0] n);
    if (n == 5'd0) return x;
    return (x << n) | (x >> (6'd32 - n));
  endfunction

  function automatic word_t rot_right(word_t x, logic [4:0] n);
    if (n == 5'd0) return x;
    return (x >> n) | (x << (6'd32 - n));
  endfunction

  function automatic word_t quad_mix(word_t x);
    word_t p;
    p = x * ((x << 1) + 32'd1);
    return rot_left(p, 5'd5);
  endfunction

  // Key schedule from the current register copy; latches the round count.
  function automatic void schedule_keys();
    int unsigned r, b, nk, c, v, idx, i, j, s, k;
    word_t w, acc_a, acc_b;
    r  = (set_rounds > MAX_ROUNDS_DEF) ? MAX_ROUNDS_DEF : set_rounds;
    b  = (set_key_len > MAX_KEY_BYTES_DEF) ? MAX_KEY_BYTES_DEF : set_key_len;
    nk = 2 * r + 4;
    c  = (b + 3) / 4;
    if (c == 0) c = 1;
    // Bytes at or beyond the key length count as zero.
    for (i = 0; i < c; i++) begin
      w = '0;
      for (k = 0; k < 4; k++) begin
        idx = 4 * i + k;
        if (idx < b) w |= word_t'(set_key[idx >> 3][(idx & 7) * 8 +: 8]) << (8 * k);
      end
      key_mix[i] = w;
    end
    sched_keys[0] = P32;
    for (i = 1; i < nk; i++) sched_keys[i] = sched_keys[i-1] + Q32;
    v = 3 * ((c > nk) ? c : nk);
    acc_a = '0;
    acc_b = '0;
    i = 0;
    j = 0;
    for (s = 0; s < v; s++) begin
      acc_a = rot_left(sched_keys[i] + acc_a + acc_b, 5'd3);
      sched_keys[i] = acc_a;
      acc_b = rot_left(key_mix[j] + acc_a + acc_b, 5'(acc_a + acc_b));
      key_mix[j] = acc_b;
      i = (i + 1 == nk) ? 0 : i + 1;
      j = (j + 1 == c) ? 0 : j + 1;
    end
    used_rounds = r;
    keys_ok = 1'b1;
  endfunction

  function automatic block_res_t rc6_forward(word_t a, word_t b, word_t c, word_t d);
    word_t t, u, tmp;
    block_res_t res;
    int unsigned i;
    b += sched_keys[0];
    d += sched_keys[1];
    for (i = 1; i <= used_rounds; i++) begin
      t = quad_mix(b);
      u = quad_mix(d);
      a = rot_left(a ^ t, u[4:0]) + sched_keys[2*i];
      c = rot_left(c ^ u, t[4:0]) + sched_keys[2*i+1];
      tmp = a; a = b; b = c; c = d; d = tmp;
    end
    a += sched_keys[2*used_rounds+2];
    c += sched_keys[2*used_rounds+3];
    res = '{a: a, b: b, c: c, d: d, status: STATUS_OK};
    return res;
  endfunction

  function automatic block_res_t rc6_inverse(word_t a, word_t b, word_t c, word_t d);
    word_t t, u, tmp;
    block_res_t res;
    int unsigned i;
    c -= sched_keys[2*used_rounds+3];
    a -= sched_keys[2*used_rounds+2];
    for (i = used_rounds; i >= 1; i--) begin
      tmp = d; d = c; c = b; b = a; a = tmp;
      u = quad_mix(d);
      t = quad_mix(b);
      c = rot_right(c - sched_keys[2*i+1], t[4:0]) ^ u;
      a = rot_right(a - sched_keys[2*i], u[4:0]) ^ t;
    end
    d -= sched_keys[1];
    b -= sched_keys[0];
    res = '{a: a, b: b, c: c, d: d, status: STATUS_OK};
    return res;
  endfunction

  // Result of one input word; an expansion updates the key state.
  function automatic block_res_t predict_block(logic [1:0] op, word_t a, word_t b,
                                               word_t c, word_t d);
    block_res_t res;
    res = '0;
    if (op == CMD_ENCRYPT || op == CMD_DECRYPT) begin
      if (!keys_ok) res.status = STATUS_KEY_NOT_READY;
      else if (op == CMD_ENCRYPT) res = rc6_forward(a, b, c, d);
      else res = rc6_inverse(a, b, c, d);
    end else if (op == CMD_EXPAND) begin
      schedule_keys();
    end
    return res;
  endfunction

  // Mostly plain random words, with a share of all-zero, all-one, one-hot
  // and tiny values that give zero or small rotations.
  function automatic word_t pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(31);
      3: return word_t'($urandom_range(31));
      default: return word_t'($urandom);
    endcase
  endfunction

  // Offer one word, wait for it to be taken and record what must come back.
  task automatic send_word(logic [1:0] op, word_t a, word_t b, word_t c, word_t d,
                           bit typed, logic want_status);
    block_res_t res;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    word_a   <= a;
    word_b   <= b;
    word_c   <= c;
    word_d   <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = predict_block(op, a, b, c, d);
    if (op == CMD_ENCRYPT && res.status == STATUS_OK) last_enc = res;
    if (typed) res = '{a: '0, b: '0, c: '0, d: '0, status: want_status};
    due_blocks = {due_blocks, res};
  endtask

  // Stop offering and wait until every result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_blocks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One register write; the block is idle whenever this is called.
  task automatic cfg_put(cfg_idx_t idx, logic [63:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_ROUNDS:     set_rounds  = value[4:0];
      CFG_KEY_LENGTH: set_key_len = value[5:0];
      CFG_KEY_LO:     set_key[0]  = value;
      CFG_KEY_MID_LO: set_key[1]  = value;
      CFG_KEY_MID_HI: set_key[2]  = value;
      CFG_KEY_HI:     set_key[3]  = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  initial begin : result_side
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Compare each accepted result with the oldest one due.
  always @(posedge clk) begin : check_out
    block_res_t want;
    word_t      got [4];
    word_t      exp_w [4];
    int         k;
    if (!rst && out_valid && !out_stall) begin
      if (due_blocks.size() == 0) begin
        $display("%0t: unexpected result %h %h %h %h status %b", $time,
                 out_a, out_b, out_c, out_d, status);
        err_count++;
      end else begin
        want  = due_blocks.pop_front();
        got   = '{out_a, out_b, out_c, out_d};
        exp_w = '{want.a, want.b, want.c, want.d};
        for (k = 0; k < 4; k++) begin
          if (got[k] !== exp_w[k]) begin
            $display("%0t: word %0d expected %h actual %h", $time, k, exp_w[k], got[k]);
            err_count++;
          end
        end
        if (status !== want.status) begin
          $display("%0t: status expected %b actual %b", $time, want.status, status);
          err_count++;
        end
      end
    end
  end

  // Stimulus: directed table, then one phase per key setting.
  initial begin : stimulus
    int         p, n, pick, r;
    bit         stale;
    logic [1:0] op;
    word_t      a, b, c, d;
    logic [4:0] rnd_set;
    logic [5:0] len_set;
    logic [63:0] key_set [4];

    rst         = 1'b1;
    in_valid    = 1'b0;
    cmd         = CMD_EXPAND;
    word_a      = '0;
    word_b      = '0;
    word_c      = '0;
    word_d      = '0;
    cfg_write   = 1'b0;
    cfg_index   = CFG_ROUNDS;
    cfg_data    = '0;
    err_count   = 0;
    hold_req    = 1'b0;
    keys_ok     = 1'b0;
    used_rounds = 0;
    set_rounds  = RESET_ROUNDS;
    set_key_len = RESET_KEY_LENGTH;
    for (r = 0; r < 4; r++) set_key[r] = '0;
    last_enc      = '0;
    send_idle_pct = 19;
    recv_idle_pct = 46;

    // Blocks before expansion are refused; expansions and the unused command
    // return zero words. All other rows go through the model.
    dir_tab = '{
      '{CMD_ENCRYPT, 32'h0,        32'h0,        32'h0,        32'h0,        1, STATUS_KEY_NOT_READY},
      '{CMD_DECRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, STATUS_KEY_NOT_READY},
      '{CMD_UNUSED,  32'h12345678, 32'h9ABCDEF0, 32'h0F1E2D3C, 32'h4B5A6978, 1, STATUS_OK},
      '{CMD_EXPAND,  32'hDEADBEEF, 32'hFFFFFFFF, 32'h0,        32'h1,        1, STATUS_OK},
      '{CMD_ENCRYPT, 32'h0,        32'h0,        32'h0,        32'h0,        0, STATUS_OK},
      '{CMD_ENCRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, STATUS_OK},
      '{CMD_DECRYPT, 32'h0,        32'h0,        32'h0,        32'h0,        0, STATUS_OK},
      '{CMD_DECRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, STATUS_OK},
      '{CMD_ENCRYPT, 32'h80000000, 32'h00000001, 32'h80000000, 32'h00000001, 0, STATUS_OK},
      '{CMD_ENCRYPT, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 0, STATUS_OK},
      '{CMD_DECRYPT, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 0, STATUS_OK},
      '{CMD_UNUSED,  32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, STATUS_OK},
      '{CMD_EXPAND,  32'h0,        32'h0,        32'h0,        32'h0,        1, STATUS_OK},
      '{CMD_ENCRYPT, 32'h0000001F, 32'h00000020, 32'hFFFFFFE0, 32'h0000001F, 0, STATUS_OK},
      '{CMD_DECRYPT, 32'h00000020, 32'h0000001F, 32'h00000000, 32'hFFFFFFE0, 0, STATUS_OK}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i])
      send_word(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b, dir_tab[i].c, dir_tab[i].d,
                dir_tab[i].typed, dir_tab[i].want_status);

    for (p = 0; p < NUM_PHASES; p++) begin
      drain();
      // Idle pattern: sender light and receiver heavy, then swapped, then none.
      if (p < 4) begin
        send_idle_pct = 19;
        recv_idle_pct = 46;
      end else if (p < 8) begin
        send_idle_pct = 46;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (r = 0; r < 4; r++) key_set[r] = {$urandom, $urandom};
      // Settings: zero, saturating and ordinary round counts and lengths.
      case (p)
        0: begin rnd_set = 5'd0;  len_set = 6'd0;
             for (r = 0; r < 4; r++) key_set[r] = '0; end
        1: begin rnd_set = 5'd31; len_set = 6'd63;
             for (r = 0; r < 4; r++) key_set[r] = '1; end
        2: begin rnd_set = 5'd1;  len_set = 6'd1;  end
        3: begin rnd_set = 5'd20; len_set = 6'd32; end
        4: begin rnd_set = 5'd21; len_set = 6'd33; end
        5: begin rnd_set = 5'd19; len_set = 6'd31; end
        6: begin rnd_set = 5'd2;  len_set = 6'd4;  end
        7: begin rnd_set = 5'd20; len_set = 6'd16; end
        default: begin
          rnd_set = 5'($urandom_range(31));
          len_set = 6'($urandom_range(63));
        end
      endcase
      // Upper bits of the narrow registers are random and must be dropped.
      cfg_put(CFG_ROUNDS,     {$urandom, 27'($urandom_range(2**27 - 1)), rnd_set});
      cfg_put(CFG_KEY_LENGTH, {$urandom, 26'($urandom_range(2**26 - 1)), len_set});
      cfg_put(CFG_KEY_LO,     key_set[0]);
      cfg_put(CFG_KEY_MID_LO, key_set[1]);
      cfg_put(CFG_KEY_MID_HI, key_set[2]);
      cfg_put(CFG_KEY_HI,     key_set[3]);

      // A stale phase keeps using the previous keys until its own expansion.
      stale = (p % 4 == 3);
      if (!stale) send_word(CMD_EXPAND, pick_word(), pick_word(), pick_word(), pick_word(),
                            0, STATUS_OK);
      for (n = 0; n < PHASE_WORDS; n++) begin
        if ((p == 2 || p == 9) && n == 20) hold_req = 1'b1;
        pick = $urandom_range(99);
        if (stale && n == 10) op = CMD_EXPAND;
        else if (pick < 4) op = CMD_EXPAND;
        else if (pick < 7) op = CMD_UNUSED;
        else if (pick < 52) op = CMD_ENCRYPT;
        else op = CMD_DECRYPT;
        a = pick_word();
        b = pick_word();
        c = pick_word();
        d = pick_word();
        // Feed a recent ciphertext back now and then for a round trip.
        if (op == CMD_DECRYPT && $urandom_range(3) == 0) begin
          a = last_enc.a;
          b = last_enc.b;
          c = last_enc.c;
          d = last_enc.d;
        end
        send_word(op, a, b, c, d, 0, STATUS_OK);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
src/rc6_pkg.sv
src/rc6_ctrl.sv
src/rc6_datapath.sv
src/rc6_block_cipher.sv
test/tb.sv
